// File: rtl/swa_pkg.sv
// Shared types, constants and helpers for the sliding window ACK/retransmit block.
// Used by swa_srtt and sliding_window_ack_retransmit_control; depends on nothing.
package swa_pkg;

    localparam int TIME_TABLE_DEPTH = 1024;   // power of two; slot is the low sequence bits
    localparam int SLOT_W = $clog2(TIME_TABLE_DEPTH);

    localparam int SEQ_W   = 20;
    localparam int TIME_W  = 32;
    localparam int WIN_W   = 10;
    localparam int ALPHA_W = 9;
    localparam int CFG_W   = 20;
    localparam int CFG_ADDR_W = 2;
    localparam int KIND_W  = 2;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 96;

    localparam logic [SEQ_W-1:0]   RST_TOTAL_PACKETS = SEQ_W'(1);
    localparam logic [WIN_W-1:0]   RST_WINDOW_SIZE   = WIN_W'(100);
    localparam logic [CFG_W-1:0]   RST_INITIAL_SRTT  = CFG_W'(50000);
    localparam logic [ALPHA_W-1:0] RST_ALPHA_Q8      = ALPHA_W'(102);
    localparam logic [ALPHA_W-1:0] ALPHA_ONE         = ALPHA_W'(256);

    typedef enum logic [KIND_W-1:0] {
        KIND_SEND    = 2'd0,
        KIND_ACK     = 2'd1,
        KIND_TIMEOUT = 2'd2
    } kind_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TOTAL_PACKETS = 2'd0,
        REG_WINDOW_SIZE   = 2'd1,
        REG_INITIAL_SRTT  = 2'd2,
        REG_ALPHA_Q8      = 2'd3
    } cfg_reg_t;

    // Result of one smoothed RTT update.
    typedef struct packed {
        logic [TIME_W-1:0] srtt;
        logic [TIME_W-1:0] rto;
    } srtt_upd_t;

    function automatic logic [SEQ_W-1:0] sat20(input logic [SEQ_W:0] v);
        sat20 = v[SEQ_W] ? {SEQ_W{1'b1}} : v[SEQ_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] sat32(input logic [TIME_W+3:0] v);
        sat32 = (|v[TIME_W+3:TIME_W]) ? {TIME_W{1'b1}} : v[TIME_W-1:0];
    endfunction

endpackage

// File: rtl/swa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed. Reading and writing one address returns the old data.
module swa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/swa_srtt.sv
// Smoothed RTT update: srtt = (a*srtt + (256-a)*rtt) >> 8 and timeout = 2*srtt, saturating.
// Depends on swa_pkg.
module swa_srtt (
    input  logic [swa_pkg::ALPHA_W-1:0] alpha_q8,
    input  logic [swa_pkg::TIME_W-1:0]  srtt,
    input  logic [swa_pkg::TIME_W-1:0]  rtt,
    output swa_pkg::srtt_upd_t          upd
);
    import swa_pkg::*;

    logic [ALPHA_W-1:0]          alpha;
    logic signed [TIME_W:0]      diff;
    logic signed [TIME_W+10:0]   prod;
    logic signed [TIME_W+10:0]   mix;
    logic [TIME_W-1:0]           srtt_new;

    // The mix is rewritten as 256*rtt + a*(srtt - rtt) so that one multiplier suffices.
    always_comb
    begin
        alpha    = (alpha_q8 > ALPHA_ONE) ? ALPHA_ONE : alpha_q8;
        diff     = $signed({1'b0, srtt}) - $signed({1'b0, rtt});
        prod     = $signed({1'b0, alpha}) * diff;
        mix      = $signed({3'b000, rtt, 8'h00}) + prod;
        srtt_new = mix[TIME_W+7:8];
        upd.srtt = srtt_new;
        upd.rto  = srtt_new[TIME_W-1] ? {TIME_W{1'b1}} : {srtt_new[TIME_W-2:0], 1'b0};
    end

endmodule

// File: rtl/sliding_window_ack_retransmit_control.sv
// Go-back-N sender window and retransmit control with fast retransmit.
// Depends on swa_pkg, swa_ram and swa_srtt.
//
// Usage: each item on the s_axis channel is one event, selected by s_axis_tuser: a
// send slot request, a received ACK, or an expired retransmit timer. Every item gives
// exactly one result item on m_axis: whether a slot was granted and with which
// sequence number, the current retransmit timeout, the window limit, the highest
// ACK and the done flag.
// One item is taken every cycle while the output is not stalled. The item is
// registered together with the send-time table read, all state is updated when
// it leaves the input stage, and the result waits in an output register. A send
// grant and an ACK read for the same slot in adjacent cycles are resolved by
// forwarding the write.
// When m_axis_tready is low the output register holds its result, the held item
// waits in the input stage and s_axis_tready drops; nothing is lost.
// Reset restores the register defaults and the window state; the send-time table
// is not cleared, so an ACK must only name a sequence that has been granted.
// Configuration writes on cfg_we take effect at once; the user must make them only while idle, unchecked by the block.
module sliding_window_ack_retransmit_control (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [swa_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [swa_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [19:0] ack_seq, [51:20] now_us, [55:52] zero
    input  logic [swa_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [1:0] kind
    input  logic [swa_pkg::KIND_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [19:0] send_seq, [51:20] timeout_us, [71:52] window_limit,
    // [91:72] highest_ack, [92] transfer_done, [95:93] zero
    output logic [swa_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // [0] send_valid
    output logic                             m_axis_tuser,
    // send_is_last
    output logic                             m_axis_tlast
);
    import swa_pkg::*;

    // Configuration registers.
    logic [SEQ_W-1:0]   total_packets_reg;
    logic [WIN_W-1:0]   window_size_reg;
    logic [ALPHA_W-1:0] alpha_q8_reg;

    // Window state.
    logic [SEQ_W-1:0]  next_seq_reg, next_seq_next;
    logic [SEQ_W-1:0]  window_end_reg, window_end_next;
    logic [SEQ_W-1:0]  ack_high_reg, ack_high_next;
    logic [SEQ_W-1:0]  prev_ack_reg, prev_ack_next;
    logic [SEQ_W-1:0]  prev_ack_older_reg, prev_ack_older_next;
    logic [TIME_W-1:0] srtt_reg, srtt_next;
    logic [TIME_W-1:0] rto_reg, rto_next;

    // Input stage.
    logic              s1_valid_reg;
    logic [KIND_W-1:0] s1_kind_reg;
    logic [SEQ_W-1:0]  s1_ack_reg;
    logic [TIME_W-1:0] s1_now_reg;
    logic              byp_reg;
    logic [TIME_W-1:0] byp_data_reg;

    // Output stage.
    logic              out_valid_reg;
    logic              out_send_valid_reg;
    logic [SEQ_W-1:0]  out_seq_reg;
    logic              out_last_reg;
    logic [TIME_W-1:0] out_rto_reg;
    logic [SEQ_W-1:0]  out_win_reg;
    logic [SEQ_W-1:0]  out_ack_high_reg;
    logic              out_done_reg;

    logic              in_accept;
    logic              out_free;
    logic              s1_go;
    logic              done_now;
    logic              grant;
    logic [SEQ_W-1:0]  in_ack;
    logic [TIME_W-1:0] in_now;
    logic [TIME_W-1:0] ram_rdata;
    logic [TIME_W-1:0] sent_time;
    logic [TIME_W-1:0] rtt;
    logic [TIME_W+3:0] rto_ten;
    logic [SLOT_W-1:0] wr_slot;
    logic [SLOT_W-1:0] rd_slot;
    srtt_upd_t         upd;

    assign in_ack  = s_axis_tdata[SEQ_W-1:0];
    assign in_now  = s_axis_tdata[SEQ_W+TIME_W-1:SEQ_W];
    assign rd_slot = in_ack[SLOT_W-1:0];
    assign wr_slot = next_seq_reg[SLOT_W-1:0];

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s1_go         = s1_valid_reg && out_free;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign done_now = ack_high_reg >= total_packets_reg;
    assign grant    = s1_valid_reg && (s1_kind_reg == KIND_SEND) && !done_now
                      && (next_seq_reg <= window_end_reg)
                      && (next_seq_reg <= total_packets_reg);

    swa_ram #(
        .WIDTH (TIME_W),
        .DEPTH (TIME_TABLE_DEPTH)
    ) u_send_time (
        .clk   (clk),
        .we    (grant && s1_go),
        .waddr (wr_slot),
        .wdata (s1_now_reg),
        .re    (in_accept),
        .raddr (rd_slot),
        .rdata (ram_rdata)
    );

    assign sent_time = byp_reg ? byp_data_reg : ram_rdata;
    assign rtt       = s1_now_reg - sent_time;
    assign rto_ten   = {1'b0, srtt_reg, 3'b000} + {3'b000, srtt_reg, 1'b0};

    swa_srtt u_srtt (
        .alpha_q8 (alpha_q8_reg),
        .srtt     (srtt_reg),
        .rtt      (rtt),
        .upd      (upd)
    );

    always_comb
    begin
        next_seq_next       = next_seq_reg;
        window_end_next     = window_end_reg;
        ack_high_next       = ack_high_reg;
        prev_ack_next       = prev_ack_reg;
        prev_ack_older_next = prev_ack_older_reg;
        srtt_next           = srtt_reg;
        rto_next            = rto_reg;
        if (s1_go && !done_now)
        begin
            case (s1_kind_reg)
                KIND_SEND:
                begin
                    if (grant)
                    begin
                        next_seq_next = next_seq_reg + SEQ_W'(1);
                    end
                end
                KIND_ACK:
                begin
                    srtt_next = upd.srtt;
                    rto_next  = upd.rto;
                    if (s1_ack_reg > ack_high_reg)
                    begin
                        ack_high_next   = s1_ack_reg;
                        window_end_next = sat20({1'b0, s1_ack_reg}
                                                + {{(SEQ_W-WIN_W+1){1'b0}}, window_size_reg});
                    end
                    // A triple duplicate leaves the ACK history and the send pointer alone.
                    if (!(s1_ack_reg == prev_ack_reg && s1_ack_reg == prev_ack_older_reg))
                    begin
                        if (s1_ack_reg == prev_ack_reg)
                        begin
                            next_seq_next   = sat20({1'b0, prev_ack_reg} + (SEQ_W+1)'(1));
                            window_end_next = sat20({1'b0, prev_ack_reg} + (SEQ_W+1)'(1)
                                                    + {{(SEQ_W-WIN_W+1){1'b0}}, window_size_reg});
                        end
                        prev_ack_older_next = prev_ack_reg;
                        prev_ack_next       = s1_ack_reg;
                    end
                end
                KIND_TIMEOUT:
                begin
                    next_seq_next   = sat20({1'b0, ack_high_reg} + (SEQ_W+1)'(1));
                    rto_next        = sat32(rto_ten);
                    window_end_next = sat20({1'b0, ack_high_reg} + (SEQ_W+1)'(1)
                                            + {{(SEQ_W-WIN_W+1){1'b0}}, window_size_reg});
                end
                default:
                begin
                    next_seq_next = next_seq_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_packets_reg  <= RST_TOTAL_PACKETS;
            window_size_reg    <= RST_WINDOW_SIZE;
            alpha_q8_reg       <= RST_ALPHA_Q8;
            next_seq_reg       <= SEQ_W'(1);
            window_end_reg     <= {{(SEQ_W-WIN_W){1'b0}}, RST_WINDOW_SIZE};
            ack_high_reg       <= '0;
            prev_ack_reg       <= '0;
            prev_ack_older_reg <= '0;
            srtt_reg           <= {{(TIME_W-CFG_W){1'b0}}, RST_INITIAL_SRTT};
            rto_reg            <= TIME_W'(3 * RST_INITIAL_SRTT);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_TOTAL_PACKETS:
                begin
                    total_packets_reg <= cfg_wdata[SEQ_W-1:0];
                end
                REG_WINDOW_SIZE:
                begin
                    window_size_reg <= cfg_wdata[WIN_W-1:0];
                    window_end_reg  <= {{(SEQ_W-WIN_W){1'b0}}, cfg_wdata[WIN_W-1:0]};
                end
                REG_INITIAL_SRTT:
                begin
                    srtt_reg <= {{(TIME_W-CFG_W){1'b0}}, cfg_wdata};
                    rto_reg  <= {{(TIME_W-CFG_W-1){1'b0}}, cfg_wdata, 1'b0}
                                + {{(TIME_W-CFG_W){1'b0}}, cfg_wdata};
                end
                REG_ALPHA_Q8:
                begin
                    alpha_q8_reg <= cfg_wdata[ALPHA_W-1:0];
                end
                default:
                begin
                    alpha_q8_reg <= alpha_q8_reg;
                end
            endcase
        end
        else
        begin
            next_seq_reg       <= next_seq_next;
            window_end_reg     <= window_end_next;
            ack_high_reg       <= ack_high_next;
            prev_ack_reg       <= prev_ack_next;
            prev_ack_older_reg <= prev_ack_older_next;
            srtt_reg           <= srtt_next;
            rto_reg            <= rto_next;
        end
    end

    // Input and output stage control; the forwarding flag covers a grant written to the slot being read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            byp_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
                byp_reg      <= grant && s1_go && (wr_slot == rd_slot);
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_kind_reg  <= s_axis_tuser;
            s1_ack_reg   <= in_ack;
            s1_now_reg   <= in_now;
            byp_data_reg <= s1_now_reg;
        end
        if (s1_go)
        begin
            out_send_valid_reg <= grant;
            out_seq_reg        <= grant ? next_seq_reg : '0;
            out_last_reg       <= grant && (next_seq_reg == total_packets_reg);
            out_rto_reg        <= rto_next;
            out_win_reg        <= window_end_next;
            out_ack_high_reg   <= ack_high_next;
            out_done_reg       <= ack_high_next >= total_packets_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_send_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {3'b000, out_done_reg, out_ack_high_reg, out_win_reg,
                            out_rto_reg, out_seq_reg};

`ifndef SYNTHESIS
    // The input side never waits on an empty output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled with the output register empty");

    // A last-segment mark only comes with a grant.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
        else $error("send_is_last without send_valid");

    // A granted sequence never lies beyond the window reported with it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (out_seq_reg <= out_win_reg))
        else $error("granted sequence beyond the window limit");

    // Once the transfer is done, an item leaves the window state untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && done_now && !cfg_we) |=> ($stable(next_seq_reg) && $stable(ack_high_reg)
                                           && $stable(window_end_reg)))
        else $error("window state changed after the transfer was done");
`endif

endmodule

// File: verif/swa_window_checker.sv
// Scoreboard for the sliding window ACK/retransmit block: watches the configuration
// port and both streams, predicts every result item and compares it field by field.
// Depends on swa_pkg for widths, event kinds, register indexes and reset values.
`timescale 1ns / 1ps

module swa_window_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [swa_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [swa_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // [19:0] ack_seq, [51:20] now_us, [55:52] zero
    input  logic [swa_pkg::IN_DATA_W-1:0]    s_tdata,
    // [1:0] kind
    input  logic [swa_pkg::KIND_W-1:0]       s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // [19:0] send_seq, [51:20] timeout_us, [71:52] window_limit,
    // [91:72] highest_ack, [92] transfer_done, [95:93] zero
    input  logic [swa_pkg::OUT_DATA_W-1:0]   m_tdata,
    // [0] send_valid
    input  logic                             m_tuser,
    input  logic                             m_tlast,
    output int                               errors,
    output int                               pending
);
    import swa_pkg::*;

    typedef struct packed {
        logic              grant;
        logic [SEQ_W-1:0]  seq;
        logic              last;
        logic [TIME_W-1:0] rto;
        logic [SEQ_W-1:0]  win;
        logic [SEQ_W-1:0]  high;
        logic              done;
    } window_result_t;

    window_result_t expected_results[$];

    int mismatches = 0;
    int queued = 0;

    assign errors  = mismatches;
    assign pending = queued;

    // Register copies.
    logic [SEQ_W-1:0]   total_packets;
    logic [WIN_W-1:0]   window_size;
    logic [CFG_W-1:0]   initial_srtt;
    logic [ALPHA_W-1:0] alpha_q8;

    // Window and timer state.
    logic [SEQ_W-1:0]   next_seq;
    logic [SEQ_W-1:0]   window_end;
    logic [SEQ_W-1:0]   ack_high;
    logic [SEQ_W-1:0]   prev_ack;
    logic [SEQ_W-1:0]   prev_older;
    logic [TIME_W-1:0]  srtt;
    logic [TIME_W-1:0]  rto;
    logic [TIME_W-1:0]  grant_time [TIME_TABLE_DEPTH];

    function automatic logic [SEQ_W-1:0] clamp_seq(input logic [SEQ_W+1:0] v);
        return (v > {2'b00, {SEQ_W{1'b1}}}) ? {SEQ_W{1'b1}} : v[SEQ_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] clamp_time(input logic [TIME_W+3:0] v);
        return (v > {4'b0000, {TIME_W{1'b1}}}) ? {TIME_W{1'b1}} : v[TIME_W-1:0];
    endfunction

    task automatic restore_defaults();
        total_packets = RST_TOTAL_PACKETS;
        window_size   = RST_WINDOW_SIZE;
        initial_srtt  = RST_INITIAL_SRTT;
        alpha_q8      = RST_ALPHA_Q8;
        next_seq      = SEQ_W'(1);
        window_end    = SEQ_W'(window_size);
        ack_high      = '0;
        prev_ack      = '0;
        prev_older    = '0;
        srtt          = TIME_W'(initial_srtt);
        rto           = clamp_time(36'(initial_srtt) * 3);
        expected_results.delete();
    endtask

    task automatic apply_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
        case (cfg_reg_t'(addr))
            REG_TOTAL_PACKETS: total_packets = data[SEQ_W-1:0];
            REG_WINDOW_SIZE:
            begin
                window_size = data[WIN_W-1:0];
                window_end  = SEQ_W'(window_size);
            end
            REG_INITIAL_SRTT:
            begin
                initial_srtt = data;
                srtt         = TIME_W'(data);
                rto          = clamp_time(36'(data) * 3);
            end
            REG_ALPHA_Q8: alpha_q8 = data[ALPHA_W-1:0];
            default: ;
        endcase
    endtask

    // Advances the state by one event and returns the result item it gives.
    function automatic window_result_t predict_event(input logic [KIND_W-1:0] kind,
                                                     input logic [SEQ_W-1:0] ack,
                                                     input logic [TIME_W-1:0] now);
        window_result_t res;
        logic [ALPHA_W-1:0] weight;
        logic [TIME_W-1:0]  rtt;
        logic [63:0]        mix;
        res = '0;
        if (ack_high < total_packets)
        begin
            case (kind)
                KIND_SEND:
                begin
                    if (next_seq <= window_end && next_seq <= total_packets)
                    begin
                        res.grant = 1'b1;
                        res.seq   = next_seq;
                        res.last  = (next_seq == total_packets);
                        grant_time[next_seq[SLOT_W-1:0]] = now;
                        next_seq = next_seq + 1'b1;
                    end
                end
                KIND_ACK:
                begin
                    weight = (alpha_q8 > ALPHA_ONE) ? ALPHA_ONE : alpha_q8;
                    rtt    = now - grant_time[ack[SLOT_W-1:0]];
                    mix    = 64'(weight) * 64'(srtt) + 64'(ALPHA_ONE - weight) * 64'(rtt);
                    srtt   = mix[TIME_W+7:8];
                    rto    = clamp_time(36'(srtt) * 2);
                    if (ack > ack_high)
                    begin
                        ack_high   = ack;
                        window_end = clamp_seq(22'(ack) + 22'(window_size));
                    end
                    // A third identical ACK leaves the history and the window base alone.
                    if (!(ack == prev_ack && ack == prev_older))
                    begin
                        if (ack == prev_ack)
                        begin
                            next_seq   = clamp_seq(22'(prev_ack) + 22'd1);
                            window_end = clamp_seq(22'(prev_ack) + 22'd1 + 22'(window_size));
                        end
                        prev_older = prev_ack;
                        prev_ack   = ack;
                    end
                end
                KIND_TIMEOUT:
                begin
                    next_seq   = clamp_seq(22'(ack_high) + 22'd1);
                    rto        = clamp_time(36'(srtt) * 10);
                    window_end = clamp_seq(22'(ack_high) + 22'd1 + 22'(window_size));
                end
                default: ;
            endcase
        end
        res.rto  = rto;
        res.win  = window_end;
        res.high = ack_high;
        res.done = (ack_high >= total_packets);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                               input logic [TIME_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        window_result_t got;
        window_result_t want;
        if (!rst_n)
        begin
            restore_defaults();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.grant = m_tuser;
                got.seq   = m_tdata[19:0];
                got.last  = m_tlast;
                got.rto   = m_tdata[51:20];
                got.win   = m_tdata[71:52];
                got.high  = m_tdata[91:72];
                got.done  = m_tdata[92];
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $error("result item with no event waiting for it");
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("send_valid", TIME_W'(want.grant), TIME_W'(got.grant));
                    check_field("send_seq", TIME_W'(want.seq), TIME_W'(got.seq));
                    check_field("send_is_last", TIME_W'(want.last), TIME_W'(got.last));
                    check_field("timeout_us", want.rto, got.rto);
                    check_field("window_limit", TIME_W'(want.win), TIME_W'(got.win));
                    check_field("highest_ack", TIME_W'(want.high), TIME_W'(got.high));
                    check_field("transfer_done", TIME_W'(want.done), TIME_W'(got.done));
                    check_field("tdata padding", '0, TIME_W'(m_tdata[95:93]));
                end
            end
            if (cfg_we)
            begin
                apply_write(cfg_addr, cfg_wdata);
            end
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(predict_event(s_tuser, s_tdata[19:0],
                                                         s_tdata[51:20]));
            end
        end
        queued = expected_results.size();
    end

endmodule

// File: verif/tb_sliding_window_ack_retransmit_control.sv
// Top of the sliding window ACK/retransmit testbench: clock, reset, configuration
// phases, event stimulus and receiver stalls; swa_window_checker does the checking.
// Depends on swa_pkg, the block under test and swa_window_checker.
`timescale 1ns / 1ps

module tb_sliding_window_ack_retransmit_control;
    import swa_pkg::*;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int MAX_TOTAL       = 999999;
    localparam int MAX_SRTT        = 1000000;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_W-1:0]       cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    logic [KIND_W-1:0]      s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;

    int errors;
    int pending;

    // What the stimulus knows of the block, taken from the result stream.
    bit               seen_slot [TIME_TABLE_DEPTH];
    bit               any_grant = 1'b0;
    logic [SEQ_W-1:0] last_grant = '0;
    logic [SEQ_W-1:0] last_high = '0;

    logic [SEQ_W-1:0]  last_ack;
    bit                have_ack = 1'b0;
    logic [TIME_W-1:0] clock_us;

    sliding_window_ack_retransmit_control u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    swa_window_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .s_tdata   (s_axis_tdata),
        .s_tuser   (s_axis_tuser),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata),
        .m_tuser   (m_axis_tuser),
        .m_tlast   (m_axis_tlast),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #6_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Only slots whose grant has come out are ever named by an ACK.
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (m_axis_tuser)
            begin
                seen_slot[m_axis_tdata[SLOT_W-1:0]] <= 1'b1;
                last_grant <= m_axis_tdata[19:0];
                any_grant  <= 1'b1;
            end
            last_high <= m_axis_tdata[91:72];
        end
    end

    // Receiver: free running, mostly ready, mostly stalled or in fixed runs.
    initial
    begin
        int mode;
        int span;
        int tick;
        m_axis_tready = 1'b0;
        tick = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 96);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ((tick % 11) < 4);
                endcase
                tick++;
            end
        end
    end

    task automatic push_item(input logic [KIND_W-1:0] kind, input logic [SEQ_W-1:0] ack,
                             input logic [TIME_W-1:0] now);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {4'b0000, now, ack};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic pause(input int cycles);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Waits until every result has come out, then lets the pipeline fall quiet.
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly sends and ACKs of recent segments, with repeated ACKs, timers,
    // unused kinds and the odd ACK far away from the window.
    task automatic pick_event(output logic [KIND_W-1:0] kind, output logic [SEQ_W-1:0] ack);
        int r;
        logic [SEQ_W-1:0] cand;
        r    = $urandom_range(0, 99);
        kind = KIND_SEND;
        ack  = SEQ_W'($urandom);
        if (r < 48)
        begin
            kind = KIND_SEND;
        end
        else if (r < 78)
        begin
            cand = last_grant - SEQ_W'($urandom_range(0, 6));
            if (any_grant && seen_slot[cand[SLOT_W-1:0]])
            begin
                kind = KIND_ACK;
                ack  = cand;
            end
        end
        else if (r < 88)
        begin
            if (have_ack)
            begin
                kind = KIND_ACK;
                ack  = last_ack;
            end
        end
        else if (r < 94)
        begin
            kind = KIND_TIMEOUT;
        end
        else if (r < 96)
        begin
            kind = KIND_UNUSED;
        end
        else if (any_grant)
        begin
            cand = SEQ_W'($urandom);
            if ($urandom_range(0, 1) != 0)
                cand = {SEQ_W{1'b1}} - SEQ_W'($urandom_range(0, 3));
            if (!seen_slot[cand[SLOT_W-1:0]])
                cand = {cand[SEQ_W-1:SLOT_W], last_grant[SLOT_W-1:0]};
            kind = KIND_ACK;
            ack  = cand;
        end
        if (kind == KIND_ACK)
        begin
            last_ack = ack;
            have_ack = 1'b1;
        end
        clock_us = clock_us + $urandom_range(0, 2000);
        if ($urandom_range(0, 63) == 0)
            clock_us = $urandom;
    endtask

    initial
    begin
        int unsigned total;
        int left;
        int burst;
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  ack;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = REG_TOTAL_PACKETS;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = KIND_SEND;
        s_axis_tdata  = '0;
        clock_us      = $urandom;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: a one-segment transfer.
        push_item(KIND_SEND, 20'hFFFFF, 32'd0);
        push_item(KIND_SEND, 20'd0, 32'd5);          // past the total
        push_item(KIND_UNUSED, 20'h5A5A5, 32'hFFFF_FFFF);
        push_item(KIND_TIMEOUT, 20'd0, 32'd10);
        push_item(KIND_SEND, 20'd0, 32'd1000);
        push_item(KIND_ACK, 20'd1, 32'd3000);        // completes the transfer
        push_item(KIND_SEND, 20'd0, 32'd3100);
        push_item(KIND_ACK, 20'd1, 32'd3200);
        settle();

        write_reg(REG_TOTAL_PACKETS, CFG_W'(MAX_TOTAL));
        write_reg(REG_WINDOW_SIZE, CFG_W'(1));
        write_reg(REG_INITIAL_SRTT, CFG_W'(1));
        write_reg(REG_ALPHA_Q8, CFG_W'(0));
        push_item(KIND_SEND, 20'd0, 32'd100);        // window full
        push_item(KIND_ACK, 20'd1, 32'd200);         // duplicate, fast retransmit
        push_item(KIND_SEND, 20'd0, 32'hFFFF_FFFF);
        push_item(KIND_SEND, 20'd0, 32'd0);
        push_item(KIND_SEND, 20'd0, 32'd1);
        push_item(KIND_ACK, 20'd3, 32'hFFFF_FFFF);   // largest round trip
        push_item(KIND_ACK, 20'd3, 32'd5);
        push_item(KIND_ACK, 20'd3, 32'd10);          // third in a row
        push_item(KIND_ACK, 20'd2, 32'hFFFF_FFFE);   // time wraps
        push_item(KIND_TIMEOUT, 20'd0, 32'd20);      // timeout saturates
        settle();

        write_reg(REG_WINDOW_SIZE, CFG_W'(1023));
        write_reg(REG_INITIAL_SRTT, CFG_W'(MAX_SRTT));
        write_reg(REG_ALPHA_Q8, CFG_W'(ALPHA_ONE));
        push_item(KIND_SEND, 20'd0, 32'd5000);
        push_item(KIND_ACK, 20'd4, 32'd9000);
        settle();

        write_reg(REG_ALPHA_Q8, CFG_W'(511));        // weight above one
        push_item(KIND_ACK, 20'd4, 32'd12000);
        push_item(KIND_TIMEOUT, 20'd0, 32'd13000);

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            total = last_high + $urandom_range(8, 200);
            if (total > MAX_TOTAL)
                total = MAX_TOTAL;
            if (p == PHASES - 1)
                total = {SEQ_W{1'b1}};
            write_reg(REG_TOTAL_PACKETS, CFG_W'(total));
            case (p % 4)
                0: write_reg(REG_WINDOW_SIZE, CFG_W'(1));
                1: write_reg(REG_WINDOW_SIZE, CFG_W'(1023));
                default: write_reg(REG_WINDOW_SIZE, CFG_W'($urandom_range(1, 1023)));
            endcase
            case (p % 3)
                0: write_reg(REG_INITIAL_SRTT, CFG_W'(MAX_SRTT));
                1: write_reg(REG_INITIAL_SRTT, CFG_W'(1));
                default: write_reg(REG_INITIAL_SRTT, CFG_W'($urandom_range(1, MAX_SRTT)));
            endcase
            case (p % 4)
                0: write_reg(REG_ALPHA_Q8, CFG_W'(ALPHA_ONE));
                1: write_reg(REG_ALPHA_Q8, CFG_W'(0));
                2: write_reg(REG_ALPHA_Q8, CFG_W'($urandom_range(257, 511)));
                default: write_reg(REG_ALPHA_Q8, CFG_W'($urandom_range(0, 256)));
            endcase

            left = ITEMS_PER_PHASE;
            while (left > 0)
            begin
                burst = $urandom_range(1, 24);
                while (burst > 0 && left > 0)
                begin
                    pick_event(kind, ack);
                    push_item(kind, ack, clock_us);
                    burst--;
                    left--;
                end
                if ($urandom_range(0, 3) != 0)
                    pause($urandom_range(1, 8));
            end
        end

        settle();
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
